### design/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants for the point-in-polygon block
// Table geometry, datapath widths and the control and status structs passed
// between the sequencer and the cross-product unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int COORD_BITS   = 16;

  // table address and vertex count widths
  localparam int ADDR_W = $clog2(MAX_VERTICES);
  localparam int CNT_W  = 5;

  // datapath widths: difference, product, cross product
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;

  // one table entry holds y above x
  localparam int VTX_W = 2 * COORD_BITS;

  // input kinds carried on tuser
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic load_pt;     // latch the query point
    logic load_a;      // latch the first vertex as edge start
    logic load_edge;   // form the differences for the next edge
    logic mul_second;  // multiplier takes qx * dy instead of dx * qy
    logic cap_p1;      // hold the first product
  } unit_ctrl_t;

  typedef struct packed {
    logic pos;
    logic neg;
  } edge_sign_t;

endpackage

`default_nettype wire

### design/pip_ram.sv
// ----------------------------------------------------------------------------
// pip_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### design/pip_cross_unit.sv
// ----------------------------------------------------------------------------
// pip_cross_unit: shared cross-product datapath
// Forms edge and point differences, runs both products of one edge through
// a single registered multiplier and reports the sign of their difference.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pip_cross_unit (
  input  wire logic                                clk,
  input  wire pip_pkg::unit_ctrl_t                 ctrl,
  input  wire logic [pip_pkg::COORD_BITS-1:0]      pt_x,
  input  wire logic [pip_pkg::COORD_BITS-1:0]      pt_y,
  input  wire logic [pip_pkg::VTX_W-1:0]           vtx,
  output pip_pkg::edge_sign_t                      sign
);

  localparam int C = pip_pkg::COORD_BITS;
  localparam int D = pip_pkg::DIFF_W;
  localparam int P = pip_pkg::PROD_W;
  localparam int R = pip_pkg::CROSS_W;

  logic        [C-1:0] px, py, ax, ay;
  logic signed [D-1:0] dx, dy, qx, qy;
  logic signed [D-1:0] mul_a, mul_b;
  logic signed [P-1:0] prod, mul_q, p1;
  logic signed [R-1:0] cross_val;
  logic        [C-1:0] vx, vy;

  function automatic logic signed [D-1:0] sub_ext(input logic [C-1:0] a,
                                                  input logic [C-1:0] b);
    return $signed({a[C-1], a}) - $signed({b[C-1], b});
  endfunction

  assign vx = vtx[C-1:0];
  assign vy = vtx[2*C-1:C];

  always_ff @(posedge clk) begin
    if (ctrl.load_pt) begin
      px <= pt_x;
      py <= pt_y;
    end
    if (ctrl.load_a) begin
      ax <= vx;
      ay <= vy;
    end
    if (ctrl.load_edge) begin
      // end vertex becomes the start of the following edge
      dx <= sub_ext(vx, ax);
      dy <= sub_ext(vy, ay);
      qx <= sub_ext(px, ax);
      qy <= sub_ext(py, ay);
      ax <= vx;
      ay <= vy;
    end
  end

  assign mul_a = ctrl.mul_second ? qx : dx;
  assign mul_b = ctrl.mul_second ? dy : qy;
  assign prod  = P'(mul_a) * P'(mul_b);

  always_ff @(posedge clk) begin
    mul_q <= prod;
    if (ctrl.cap_p1) begin
      p1 <= mul_q;
    end
  end

  assign cross_val = R'(p1) - R'(mul_q);
  assign sign.neg  = cross_val[R-1];
  assign sign.pos  = !cross_val[R-1] && (cross_val != '0);

endmodule

`default_nettype wire

### design/pip_ctrl.sv
// ----------------------------------------------------------------------------
// pip_ctrl: query sequencer
// Walks the vertex table edge by edge, drives the cross-product unit and
// compares each edge sign with the first edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pip_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [pip_pkg::CNT_W-1:0]   n_eff,
  input  wire pip_pkg::edge_sign_t         sign,
  input  wire logic                        out_busy,
  output logic                             idle,
  output logic [pip_pkg::ADDR_W-1:0]       rd_addr,
  output pip_pkg::unit_ctrl_t              ctrl,
  output logic                             done,
  output logic                             in_poly
);

  localparam int A = pip_pkg::ADDR_W;
  localparam int N = pip_pkg::CNT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_LOADA = 3'd2;
  localparam logic [2:0] S_LOADB = 3'd3;
  localparam logic [2:0] S_MUL1  = 3'd4;
  localparam logic [2:0] S_MUL2  = 3'd5;
  localparam logic [2:0] S_SIGN  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]   state, state_next;
  logic [A-1:0] rd_ptr, rd_ptr_next;
  logic [A-1:0] edge_idx, edge_idx_next;
  logic [N-1:0] n_reg;
  logic         first_pos, first_neg;
  logic         in_poly_next;
  logic         last_edge, mismatch;

  // wrap the read pointer at the vertex count
  function automatic logic [A-1:0] wrap_next(input logic [A-1:0] i,
                                             input logic [N-1:0] n);
    logic [N-1:0] inc;
    inc = N'(i) + N'(1);
    return (inc == n) ? '0 : A'(inc);
  endfunction

  assign last_edge = (N'(edge_idx) + N'(1)) == n_reg;
  assign mismatch  = (edge_idx != '0) &&
                     ((first_pos && sign.neg) || (first_neg && sign.pos));

  always_comb begin
    state_next    = state;
    rd_ptr_next   = rd_ptr;
    edge_idx_next = edge_idx;
    in_poly_next  = in_poly;
    ctrl          = '0;
    done          = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.load_pt = 1'b1;
          rd_ptr_next  = '0;
          state_next   = S_START;
        end
      end
      S_START: begin
        rd_ptr_next = wrap_next(rd_ptr, n_reg);
        state_next  = S_LOADA;
      end
      S_LOADA: begin
        ctrl.load_a = 1'b1;
        rd_ptr_next = wrap_next(rd_ptr, n_reg);
        state_next  = S_LOADB;
      end
      S_LOADB: begin
        ctrl.load_edge = 1'b1;
        edge_idx_next  = '0;
        state_next     = S_MUL1;
      end
      S_MUL1: begin
        state_next = S_MUL2;
      end
      S_MUL2: begin
        ctrl.mul_second = 1'b1;
        ctrl.cap_p1     = 1'b1;
        state_next      = S_SIGN;
      end
      S_SIGN: begin
        if (mismatch) begin
          in_poly_next = 1'b0;
          state_next   = S_OUT;
        end else if (last_edge) begin
          in_poly_next = 1'b1;
          state_next   = S_OUT;
        end else begin
          ctrl.load_edge = 1'b1;
          rd_ptr_next    = wrap_next(rd_ptr, n_reg);
          edge_idx_next  = edge_idx + A'(1);
          state_next     = S_MUL1;
        end
      end
      S_OUT: begin
        // hold until the previous result has been taken
        if (!out_busy) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr   <= rd_ptr_next;
    edge_idx <= edge_idx_next;
    in_poly  <= in_poly_next;
    if (state == S_IDLE && start) begin
      n_reg <= n_eff;
    end
    if (state == S_SIGN && edge_idx == '0) begin
      first_pos <= sign.pos;
      first_neg <= sign.neg;
    end
  end

  assign idle    = (state == S_IDLE);
  assign rd_addr = rd_ptr;

endmodule

`default_nettype wire

### design/point_in_convex_polygon.sv
// ----------------------------------------------------------------------------
// point_in_convex_polygon: convex polygon membership test
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tdata, s_tuser (0 write vertex, 1 query)
//   m_*      out  m_tvalid/m_tready  m_tdata[0] inside_res
//   cfg_*    in   cfg_valid/cfg_ready cfg_data vertex_count
//
// A vertex write is taken whenever the sequencer is idle. A query over n vertices
// in use visits n edges: one multiplier serves both products of each edge, so
// every edge passes two multiply states, then the sign check, which also loads
// the next edge, after the start-up states START, LOADA, LOADB; OUT comes last.
// A query stops early at the first edge of opposite sign. Reset clears the
// sequencer, the output valid and sets vertex_count to 3; the vertex table is
// not cleared. A finished result waits in the output register; a following
// query holds its result until that register drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module point_in_convex_polygon (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // vertex_index[3:0], coord_x[19:4], coord_y[35:20]
  input  wire logic [0:0]  s_tuser,   // command[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // inside_res[0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data   // vertex_count[4:0]
);

  localparam int C = pip_pkg::COORD_BITS;
  localparam int A = pip_pkg::ADDR_W;
  localparam int N = pip_pkg::CNT_W;

  logic [3:0]   vertex_index;
  logic [15:0]  coord_x, coord_y;
  logic         s_fire, wr_en, start;
  logic [N-1:0] vertex_count, n_eff;
  logic [A-1:0] rd_addr;
  logic [pip_pkg::VTX_W-1:0] rd_data;
  logic         idle, done, in_poly, inside_res;
  pip_pkg::unit_ctrl_t ctrl;
  pip_pkg::edge_sign_t sign;

  assign vertex_index = s_tdata[3:0];
  assign coord_x      = s_tdata[19:4];
  assign coord_y      = s_tdata[35:20];

  assign s_tready = idle;
  assign s_fire   = s_tvalid && s_tready;
  assign wr_en    = s_fire && (s_tuser[0] == pip_pkg::CMD_WRITE) &&
                    (32'(vertex_index) < pip_pkg::MAX_VERTICES);
  assign start    = s_fire && (s_tuser[0] == pip_pkg::CMD_QUERY);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= N'(3);
    end else if (cfg_valid && cfg_ready) begin
      vertex_count <= cfg_data;
    end
  end

  // zero counts as one vertex; saturate at the table depth
  always_comb begin
    if (vertex_count == '0) begin
      n_eff = N'(1);
    end else if (32'(vertex_count) > pip_pkg::MAX_VERTICES) begin
      n_eff = N'(pip_pkg::MAX_VERTICES);
    end else begin
      n_eff = vertex_count;
    end
  end

  pip_ram #(
    .WIDTH(pip_pkg::VTX_W),
    .DEPTH(pip_pkg::MAX_VERTICES)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(A'(vertex_index)),
    .wr_data({coord_y[C-1:0], coord_x[C-1:0]}),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  pip_cross_unit u_cross (
    .clk (clk),
    .ctrl(ctrl),
    .pt_x(coord_x[C-1:0]),
    .pt_y(coord_y[C-1:0]),
    .vtx (rd_data),
    .sign(sign)
  );

  pip_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .n_eff   (n_eff),
    .sign    (sign),
    .out_busy(m_tvalid),
    .idle    (idle),
    .rd_addr (rd_addr),
    .ctrl    (ctrl),
    .done    (done),
    .in_poly (in_poly)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      inside_res <= in_poly;
    end
  end

  assign m_tdata = {7'd0, inside_res};

endmodule

`default_nettype wire

### tb/sv/point_in_convex_polygon_tb.sv
// ----------------------------------------------------------------------------
// point_in_convex_polygon_tb: self-checking bench for the polygon membership block
// Loads vertex tables and sweeps the vertex count from degenerate to beyond
// the table size. Queries points inside, outside, on vertices and on edges of
// mostly convex polygons, under random stalls on both streams and repeated long
// output hold-offs. A scoreboard keeps its own vertex table and predicts every
// inside_res.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class inside_scoreboard;
  localparam int EXP_DEPTH = 1024;

  logic signed [pip_pkg::COORD_BITS-1:0] tab_x [pip_pkg::MAX_VERTICES];
  logic signed [pip_pkg::COORD_BITS-1:0] tab_y [pip_pkg::MAX_VERTICES];
  logic [4:0] count_reg;
  bit exp_buf [EXP_DEPTH];
  int exp_head;
  int exp_tail;
  int errors;
  int checked;
  int queries;

  function new();
    foreach (tab_x[i]) begin
      tab_x[i] = '0;
      tab_y[i] = '0;
    end
    count_reg = 5'd3;
    exp_head = 0;
    exp_tail = 0;
    errors = 0;
    checked = 0;
    queries = 0;
  endfunction

  function void set_count(logic [4:0] value);
    count_reg = value;
  endfunction

  // sign of (B-A) x (P-A) in exact 64-bit arithmetic
  function int edge_sign(longint ax, longint ay, longint bx, longint by,
                         longint px, longint py);
    longint cr;
    cr = (bx - ax) * (py - ay) - (px - ax) * (by - ay);
    if (cr > 0) return 1;
    if (cr < 0) return -1;
    return 0;
  endfunction

  function bit point_inside(logic signed [pip_pkg::COORD_BITS-1:0] px,
                            logic signed [pip_pkg::COORD_BITS-1:0] py);
    int n;
    int j;
    int first;
    int s;
    n = count_reg;
    if (n < 1) n = 1;
    if (n > pip_pkg::MAX_VERTICES) n = pip_pkg::MAX_VERTICES;
    first = edge_sign(tab_x[0], tab_y[0], tab_x[1 % n], tab_y[1 % n], px, py);
    for (int i = 1; i < n; i++) begin
      j = (i + 1) % n;
      s = edge_sign(tab_x[i], tab_y[i], tab_x[j], tab_y[j], px, py);
      if ((first > 0 && s < 0) || (first < 0 && s > 0)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function void note_input(logic cmd, logic [3:0] idx,
                           logic signed [pip_pkg::COORD_BITS-1:0] x,
                           logic signed [pip_pkg::COORD_BITS-1:0] y);
    if (cmd == pip_pkg::CMD_WRITE) begin
      if (idx < pip_pkg::MAX_VERTICES) begin
        tab_x[idx] = x;
        tab_y[idx] = y;
      end
    end else begin
      exp_buf[exp_tail % EXP_DEPTH] = point_inside(x, y);
      exp_tail++;
      queries++;
    end
  endfunction

  function void check_result(bit got);
    bit want;
    checked++;
    if (pending() == 0) begin
      $display("%0t: unexpected result, expected none, got inside_res %0d", $time, got);
      errors++;
      return;
    end
    want = exp_buf[exp_head % EXP_DEPTH];
    exp_head++;
    if (got !== want) begin
      $display("%0t: inside_res mismatch, expected %0d, got %0d", $time, want, got);
      errors++;
    end
  endfunction

  function int pending();
    return exp_tail - exp_head;
  endfunction
endclass

module point_in_convex_polygon_tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // vertex_index[3:0], coord_x[19:4], coord_y[35:20]
  logic [0:0]  s_tuser = '0;   // command[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // inside_res[0]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = 5'd3;

  inside_scoreboard sb = new();

  int send_idle_pct = 30;
  int recv_idle_pct = 60;
  int items_sent = 0;
  int count_writes = 0;
  bit [31:0] counts_used = '0;

  point_in_convex_polygon DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  task automatic send_item(input logic cmd, input logic [3:0] idx,
                           input logic signed [15:0] x, input logic signed [15:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {4'b0, y, x, idx};
    do @(posedge clk); while (!s_tready);
    sb.note_input(cmd, idx, x, y);
    items_sent++;
  endtask

  // drain outstanding queries, then let the sequencer settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_count(input logic [4:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_count(value);
    count_writes++;
    counts_used[value] = 1'b1;
  endtask

  // result sink with random stalls and a long hold-off now and then
  initial begin : result_sink
    int hold_left;
    int next_hold;
    hold_left = 0;
    next_hold = 120;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tdata[0]);
      if (hold_left == 0 && sb.checked >= next_hold) begin
        hold_left = 400;
        next_hold += 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    int sel;
    int cnt;
    int nn;
    int cx;
    int cy;
    int r;
    int span;
    int qx;
    int qy;
    int k;
    int nq;
    int phase_goal;
    int poly_x [16];
    int poly_y [16];
    bit reverse;
    real ang;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the whole table: a full-range square first, random vertices after
    send_item(pip_pkg::CMD_WRITE, 4'd0, -16'sd32768, -16'sd32768);
    send_item(pip_pkg::CMD_WRITE, 4'd1, 16'sd32767, -16'sd32768);
    send_item(pip_pkg::CMD_WRITE, 4'd2, 16'sd32767, 16'sd32767);
    send_item(pip_pkg::CMD_WRITE, 4'd3, -16'sd32768, 16'sd32767);
    for (int i = 4; i < pip_pkg::MAX_VERTICES; i++)
      send_item(pip_pkg::CMD_WRITE, i[3:0], 16'($urandom), 16'($urandom));

    // reset count of three: inside, outside, on the first edge, on a vertex
    send_item(pip_pkg::CMD_QUERY, 4'd15, 16'sd16000, -16'sd16000);
    send_item(pip_pkg::CMD_QUERY, 4'd0, -16'sd32768, 16'sd32767);
    send_item(pip_pkg::CMD_QUERY, 4'd7, 16'sd0, -16'sd32768);
    send_item(pip_pkg::CMD_QUERY, 4'd8, 16'sd32767, 16'sd32767);

    // zero vertices acts as one, two vertices tests both edges
    wait_idle();
    write_count(5'd0);
    send_item(pip_pkg::CMD_QUERY, 4'd0, 16'sd5, 16'sd5);
    wait_idle();
    write_count(5'd2);
    send_item(pip_pkg::CMD_QUERY, 4'd0, -16'sd32768, -16'sd32767);
    // full table, then a count past the table that saturates
    wait_idle();
    write_count(5'd16);
    send_item(pip_pkg::CMD_QUERY, 4'd0, 16'sd0, 16'sd0);
    send_item(pip_pkg::CMD_QUERY, 4'd0, 16'sd32767, -16'sd32768);
    wait_idle();
    write_count(5'd31);
    send_item(pip_pkg::CMD_QUERY, 4'd0, -16'sd1, 16'sd1);

    for (int phase = 0; phase < 3; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          send_idle_pct = 30;
          recv_idle_pct = 60;
        end
        1: begin
          send_idle_pct = 60;
          recv_idle_pct = 30;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_goal = 25 + 650 * (phase + 1) / 3;
      while (items_sent < phase_goal) begin
        sel = $urandom_range(99);
        if (sel < 70) cnt = $urandom_range(8, 3);
        else if (sel < 80) cnt = 16;
        else if (sel < 85) cnt = 1;
        else if (sel < 90) cnt = 2;
        else if (sel < 95) cnt = 0;
        else cnt = $urandom_range(31, 17);
        nn = (cnt < 1) ? 1 : (cnt > pip_pkg::MAX_VERTICES) ? pip_pkg::MAX_VERTICES : cnt;

        wait_idle();
        write_count(cnt[4:0]);

        // vertices on a circle in angular order give a convex polygon
        if ($urandom_range(9) == 0) begin
          cx = 0;
          cy = 0;
          r = 46000;
        end else begin
          cx = int'($urandom_range(40000)) - 20000;
          cy = int'($urandom_range(40000)) - 20000;
          r = $urandom_range(12000, 8);
        end
        reverse = $urandom_range(1);
        for (int i = 0; i < nn; i++) begin
          k = reverse ? nn - 1 - i : i;
          ang = 6.283185307179586 * (k + $urandom_range(40) / 100.0) / nn;
          poly_x[i] = clamp16(int'(cx + r * $cos(ang)));
          poly_y[i] = clamp16(int'(cy + r * $sin(ang)));
          send_item(pip_pkg::CMD_WRITE, i[3:0], poly_x[i][15:0], poly_y[i][15:0]);
        end

        nq = $urandom_range(20, 10);
        for (int q = 0; q < nq; q++) begin
          // now and then overwrite a slot and break the polygon
          if ($urandom_range(99) < 5)
            send_item(pip_pkg::CMD_WRITE, 4'($urandom), 16'($urandom), 16'($urandom));
          sel = $urandom_range(99);
          k = $urandom_range(nn - 1);
          if (sel < 40) begin
            span = r * 13 / 10 + 1;
            qx = cx + int'($urandom_range(2 * span)) - span;
            qy = cy + int'($urandom_range(2 * span)) - span;
          end else if (sel < 55) begin
            qx = poly_x[k];
            qy = poly_y[k];
          end else if (sel < 65) begin
            qx = (poly_x[k] + poly_x[(k + 1) % nn]) / 2;
            qy = (poly_y[k] + poly_y[(k + 1) % nn]) / 2;
          end else if (sel < 85) begin
            qx = $signed(16'($urandom));
            qy = $signed(16'($urandom));
          end else begin
            qx = poly_x[k] + int'($urandom_range(6)) - 3;
            qy = poly_y[k] + int'($urandom_range(6)) - 3;
          end
          send_item(pip_pkg::CMD_QUERY, 4'($urandom), clamp16(qx), clamp16(qy));
        end
      end
    end

    wait_idle();
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.errors++;
    end
    $display("Sent %0d items (%0d point queries), checked %0d results.",
             items_sent, sb.queries, sb.checked);
    $display("Vertex count written %0d times, %0d distinct values from 0 to 31.",
             count_writes, $countones(counts_used));
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### files.f
design/pip_pkg.sv
design/pip_ram.sv
design/pip_cross_unit.sv
design/pip_ctrl.sv
design/point_in_convex_polygon.sv
tb/sv/point_in_convex_polygon_tb.sv
